[rtl/sample_history_delay_average_macros.svh]
// Assertion macros used by the checker file of the sample history block.
`ifndef SAMPLE_HISTORY_DELAY_AVERAGE_MACROS_SVH
`define SAMPLE_HISTORY_DELAY_AVERAGE_MACROS_SVH
// Same-cycle implication, disabled while reset is asserted.
`define SHDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define SHDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/shda_pkg.sv]
// Package with types, constants and codes of the sample history block.
`default_nettype none
package shda_pkg;
    localparam int SIZE_DEF     = 32;
    localparam int WEIGHT_COUNT = 32;
    localparam int WIDX_W       = 5;
    localparam int SMP_W        = 16;
    localparam int DELAY_W      = 5;
    localparam int WIN_W        = 6;
    localparam int STEPS_W      = 8;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 6;
    localparam int SUM_W        = 22;
    localparam int ACC_W        = 38;
    localparam int WSUM_W       = 22;
    localparam int PROD_W       = 32;
    localparam int CNT_W        = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b1;

    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_HIST   = 2'd1;
    localparam logic [1:0] KIND_WEIGHT = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [SMP_W-1:0] sample;
        logic [STEPS_W-1:0]      lookback;
        logic [WIDX_W-1:0]       weight_index;
        logic signed [SMP_W-1:0] weight_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [SMP_W-1:0] delayed_sample;
        logic signed [SMP_W-1:0] history_sample;
        logic                    history_valid;
        logic signed [SMP_W-1:0] mean;
        logic                    mean_valid;
        logic signed [SMP_W-1:0] weighted_mean;
        logic                    weighted_valid;
    } t_out_beat;

    typedef struct packed {
        logic load;
        logic apply;
        logic look;
        logic look_cap;
        logic acc_start;
        logic div_start;
        logic div_weighted;
        logic cap_mean;
        logic cap_wmean;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic acc_done;
        logic div_done;
    } t_status;
endpackage
`default_nettype wire

[rtl/shda_in_if.sv]
// Input channel interface: valid, ready and one input beat.
`default_nettype none
interface shda_in_if;
    logic               valid;
    logic               ready;
    shda_pkg::t_in_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/shda_out_if.sv]
// Output channel interface: valid, ready and one result beat.
`default_nettype none
interface shda_out_if;
    logic                valid;
    logic                ready;
    shda_pkg::t_out_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/shda_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module shda_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/shda_ctrl.sv]
// Controller state machine that sequences one item through the datapath.
`default_nettype none
module shda_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_out_free,
    input  wire shda_pkg::t_status i_status,
    output logic                   o_in_ready,
    output shda_pkg::t_cmd         o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_APPLY = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_CAP   = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;
    localparam logic [2:0] S_DIVM  = 3'd5;
    localparam logic [2:0] S_DIVW  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_LOOK;
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_CAP;
            end
            S_CAP: begin
                o_cmd.look_cap  = 1'b1;
                o_cmd.acc_start = 1'b1;
                n_state         = S_ACC;
            end
            S_ACC: begin
                if (i_status.acc_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVM;
                end
            end
            S_DIVM: begin
                if (i_status.div_done) begin
                    o_cmd.cap_mean     = 1'b1;
                    o_cmd.div_start    = 1'b1;
                    o_cmd.div_weighted = 1'b1;
                    n_state            = S_DIVW;
                end
            end
            S_DIVW: begin
                if (i_status.div_done) begin
                    o_cmd.cap_wmean = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output register can take the beat
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

[rtl/shda_datapath.sv]
// Datapath: sample ring, weight table, accumulator and shared divider.
`default_nettype none
module shda_datapath #(
    parameter int SIZE = shda_pkg::SIZE_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire shda_pkg::t_in_beat               i_beat,
    input  wire logic                             i_cfg_we,
    input  wire logic [shda_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [shda_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire shda_pkg::t_cmd                   i_cmd,
    output shda_pkg::t_status                     o_status,
    output shda_pkg::t_out_beat                   o_result
);
    localparam int AW = $clog2(SIZE);
    localparam int CW = $clog2(SIZE + 1);
    localparam int LW = AW + 9;
    localparam int SW = shda_pkg::SMP_W;
    localparam int ACW = shda_pkg::ACC_W;
    localparam int SMW = shda_pkg::SUM_W;
    localparam int WSW = shda_pkg::WSUM_W;
    localparam int KW = shda_pkg::CNT_W;
    localparam int WAW = shda_pkg::WIDX_W;

    shda_pkg::t_in_beat r_item;
    logic [shda_pkg::DELAY_W-1:0] r_delay;
    logic [shda_pkg::WIN_W-1:0]   r_window;
    logic [AW-1:0]                r_wp;
    logic [CW-1:0]                r_fill;
    logic [shda_pkg::WEIGHT_COUNT-1:0] r_wvalid;

    logic                 ring_we;
    logic [AW-1:0]        ring_raddr;
    logic [SW-1:0]        ring_q;
    logic                 wram_we;
    logic [SW-1:0]        wram_q;

    logic                 r_dok;
    logic                 r_hok;
    logic signed [SW-1:0] r_delayed;
    logic signed [SW-1:0] r_hist;
    logic                 r_hvalid;

    logic                 r_win_ok;
    logic [KW-1:0]        r_n;
    logic [KW-1:0]        r_k;
    logic                 r_issue;
    logic                 r_d1;
    logic                 r_d1_wok;
    logic                 r_d2;
    logic signed [SW-1:0] r_s;
    logic signed [SW-1:0] r_w;
    logic signed [shda_pkg::PROD_W-1:0] r_p;
    logic signed [SMW-1:0] r_sum;
    logic signed [ACW-1:0] r_acc;
    logic signed [WSW-1:0] r_wsum;

    logic [ACW-1:0]       r_q;
    logic [WSW-1:0]       r_rem;
    logic [WSW-1:0]       r_dvs;
    logic                 r_neg;
    logic [KW-1:0]        r_cnt;
    logic signed [SW-1:0] r_mean;
    logic signed [SW-1:0] r_wmean;

    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] wp,
                                                input logic [LW-1:0] age);
        logic [LW-1:0] t;
        t = LW'(wp) + LW'(SIZE - 1) - age;
        if (t >= LW'(SIZE)) begin
            t = t - LW'(SIZE);
        end
        return t[AW-1:0];
    endfunction

    function automatic logic signed [SW-1:0] sat16(input logic [ACW-1:0] mag,
                                                   input logic neg);
        logic [ACW-1:0] m;
        logic signed [SW-1:0] v;
        m = ~mag + 1'b1;
        if (neg) begin
            v = (mag > ACW'(32768)) ? 16'sh8000 : $signed(m[SW-1:0]);
        end else begin
            v = (mag > ACW'(32767)) ? 16'sh7fff : $signed(mag[SW-1:0]);
        end
        return v;
    endfunction

    // look-up age and range checks for the delayed and history reads
    logic [LW-1:0] delay_age;
    logic [LW-1:0] look_age;
    logic          look_dok;
    logic          look_hok;
    logic [LW-1:0] n_lw;
    logic          win_ok;

    always_comb begin
        delay_age = LW'(r_delay);
        if (delay_age > LW'(SIZE - 1)) begin
            delay_age = LW'(SIZE - 1);
        end
        look_dok = (r_item.kind == shda_pkg::KIND_PUSH) && (delay_age < LW'(r_fill));
        look_hok = (r_item.kind == shda_pkg::KIND_HIST)
                && (LW'(r_item.lookback) < LW'(SIZE))
                && (LW'(r_item.lookback) < LW'(r_fill));
        look_age = (r_item.kind == shda_pkg::KIND_PUSH) ? delay_age
                                                       : LW'(r_item.lookback);
        win_ok = (r_window != '0) && (LW'(r_window) <= LW'(SIZE));
        n_lw   = (LW'(r_window) < LW'(r_fill)) ? LW'(r_window) : LW'(r_fill);
    end

    assign ring_we    = i_cmd.apply && (r_item.kind == shda_pkg::KIND_PUSH);
    assign wram_we    = i_cmd.apply && (r_item.kind == shda_pkg::KIND_WEIGHT);
    assign ring_raddr = i_cmd.look ? ring_addr(r_wp, look_age)
                                   : ring_addr(r_wp, LW'(r_k));

    shda_ram #(.WIDTH(SW), .DEPTH(SIZE)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wp),
        .i_wdata (r_item.sample),
        .i_raddr (ring_raddr),
        .o_rdata (ring_q)
    );

    shda_ram #(.WIDTH(SW), .DEPTH(shda_pkg::WEIGHT_COUNT)) u_weights (
        .i_clk   (i_clk),
        .i_we    (wram_we),
        .i_waddr (r_item.weight_index),
        .i_wdata (r_item.weight_value),
        .i_raddr (r_k[WAW-1:0]),
        .o_rdata (wram_q)
    );

    // divider operand selection
    logic [ACW-1:0] div_a;
    logic [ACW-1:0] div_mag;
    logic [WSW:0]   rem_sh;
    logic           rem_ge;

    always_comb begin
        div_a   = i_cmd.div_weighted ? r_acc : ACW'(r_sum);
        div_mag = div_a[ACW-1] ? (~div_a + 1'b1) : div_a;
        rem_sh  = {r_rem, r_q[ACW-1]};
        rem_ge  = rem_sh >= {1'b0, r_dvs};
    end

    assign o_status.acc_done = !r_issue && !r_d1 && !r_d2;
    assign o_status.div_done = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= '0;
            r_window <= shda_pkg::WIN_W'(1);
            r_wp     <= '0;
            r_fill   <= '0;
            r_wvalid <= '0;
            r_issue  <= 1'b0;
            r_d1     <= 1'b0;
            r_d2     <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    shda_pkg::CFG_DELAY:  r_delay  <= i_cfg_data[shda_pkg::DELAY_W-1:0];
                    shda_pkg::CFG_WINDOW: r_window <= i_cfg_data;
                    default: ;
                endcase
            end
            if (ring_we) begin
                r_wp <= (r_wp == AW'(SIZE - 1)) ? '0 : AW'(r_wp + 1'b1);
                if (r_fill < CW'(SIZE)) begin
                    r_fill <= CW'(r_fill + 1'b1);
                end
            end
            if (wram_we) begin
                r_wvalid[r_item.weight_index] <= 1'b1;
            end
            // accumulation pipeline: issue, fetch, add
            r_d1 <= r_issue;
            r_d2 <= r_d1;
            if (i_cmd.acc_start) begin
                r_issue <= win_ok && (n_lw != '0);
            end else if (r_issue && (KW'(r_k + 1'b1) == r_n)) begin
                r_issue <= 1'b0;
            end
            if (i_cmd.div_start) begin
                r_cnt <= i_cmd.div_weighted ? KW'(ACW) : KW'(SMW);
            end else if (r_cnt != '0) begin
                r_cnt <= KW'(r_cnt - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_beat;
        end
        if (i_cmd.look) begin
            r_dok <= look_dok;
            r_hok <= look_hok;
        end
        if (i_cmd.look_cap) begin
            r_delayed <= r_dok ? $signed(ring_q) : '0;
            r_hist    <= r_hok ? $signed(ring_q) : '0;
            r_hvalid  <= r_hok;
        end
        if (i_cmd.acc_start) begin
            r_win_ok <= win_ok;
            r_n      <= win_ok ? n_lw[KW-1:0] : '0;
            r_k      <= '0;
            r_sum    <= '0;
            r_acc    <= '0;
            r_wsum   <= '0;
        end else if (r_issue) begin
            r_k <= KW'(r_k + 1'b1);
        end
        r_d1_wok <= (r_k < KW'(shda_pkg::WEIGHT_COUNT)) && r_wvalid[r_k[WAW-1:0]];
        r_s <= $signed(ring_q);
        r_w <= r_d1_wok ? $signed(wram_q) : '0;
        r_p <= $signed(ring_q) * (r_d1_wok ? $signed(wram_q) : 16'sd0);
        if (r_d2) begin
            r_sum  <= r_sum + SMW'(r_s);
            r_acc  <= r_acc + ACW'(r_p);
            r_wsum <= r_wsum + WSW'(r_w);
        end
        // restoring division, one quotient bit a cycle
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_neg <= div_a[ACW-1];
            if (i_cmd.div_weighted) begin
                r_q   <= div_mag;
                r_dvs <= r_wsum;
            end else begin
                r_q   <= {div_mag[SMW-1:0], (ACW - SMW)'(0)};
                r_dvs <= WSW'(r_n);
            end
        end else if (r_cnt != '0) begin
            r_rem <= rem_ge ? WSW'(rem_sh - {1'b0, r_dvs}) : rem_sh[WSW-1:0];
            r_q   <= {r_q[ACW-2:0], rem_ge};
        end
        if (i_cmd.cap_mean) begin
            r_mean <= sat16(r_q, r_neg);
        end
        if (i_cmd.cap_wmean) begin
            r_wmean <= sat16(r_q, r_neg);
        end
    end

    logic mvalid;
    logic wvalid;
    assign mvalid = r_win_ok && (r_n != '0);
    assign wvalid = mvalid && !r_wsum[WSW-1] && (r_wsum != '0);

    assign o_result.delayed_sample = r_delayed;
    assign o_result.history_sample = r_hist;
    assign o_result.history_valid  = r_hvalid;
    assign o_result.mean           = mvalid ? r_mean : '0;
    assign o_result.mean_valid     = mvalid;
    assign o_result.weighted_mean  = wvalid ? r_wmean : '0;
    assign o_result.weighted_valid = wvalid;
endmodule
`default_nettype wire

[rtl/sample_history_delay_average.sv]
// Top level of the sample history, delay line and moving average block.
// One item is taken at a time and gives one result beat. An item passes
// through acceptance, setup and ring look-up, then a multiply-accumulate of
// n samples over the single ring read port, n being min(window, fill count)
// when the window is valid and 0 otherwise, then the shared one-bit-a-cycle
// divider for the mean and the weighted mean (over the 22-bit sum and the
// 38-bit product accumulator), and last the load of the output register.
// That load waits while an earlier result still sits unaccepted in the
// output register. A new item is accepted while the previous result still
// waits in the output register. There is no clearing pass after reset; the
// fill count guards the ring and per-entry valid bits guard the weight table.
`default_nettype none
module sample_history_delay_average #(
    parameter int SIZE = shda_pkg::SIZE_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    shda_in_if.sink                              i_in,
    shda_out_if.source                           o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [shda_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [shda_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    shda_pkg::t_cmd      cmd;
    shda_pkg::t_status   status;
    shda_pkg::t_out_beat result;
    shda_pkg::t_out_beat r_out_beat;
    logic                r_out_valid;
    logic                out_free;

    assign out_free = !r_out_valid || o_out.ready;

    shda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    shda_datapath #(.SIZE(SIZE)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (i_in.payload),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.emit) begin
            r_out_beat <= result;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_beat;
endmodule
`default_nettype wire

[rtl/shda_checker.sv]
// Port-level checker of the sample history block and its bind.
`default_nettype none
`include "sample_history_delay_average_macros.svh"
module shda_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire shda_pkg::t_out_beat i_out_beat
);
    `SHDA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_beat), "stalled result beat changed")
    `SHDA_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input taken while an item is in work")
    `SHDA_ASSERT_IMP(a_hist_zero, i_clk, i_rst_n, i_out_valid && !i_out_beat.history_valid, i_out_beat.history_sample == 16'sd0, "invalid history sample not zero")
    `SHDA_ASSERT_IMP(a_mean_flags, i_clk, i_rst_n, i_out_valid && !i_out_beat.mean_valid, (i_out_beat.mean == 16'sd0) && !i_out_beat.weighted_valid && (i_out_beat.weighted_mean == 16'sd0), "averages set without samples")
endmodule

bind sample_history_delay_average shda_checker u_shda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_beat  (o_out.payload)
);
`default_nettype wire
